FILE: rtl/core/tcwm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcwm_pkg
// Shared types, widths and constants for the track-to-cluster window matcher.
// ----------------------------------------------------------------------------
package tcwm_pkg;

    // Track table size and the counters that walk it
    localparam int MAX_TRACKS      = 256;
    localparam int IDX_W           = $clog2(MAX_TRACKS);
    localparam int CNT_W           = $clog2(MAX_TRACKS + 1);

    // Angle format
    localparam int ANGLE_FRAC_BITS = 12;
    localparam longint PI_Q29      = 64'sd1686629713;
    localparam longint PI_FIX      =
        (PI_Q29 + (64'sd1 << (28 - ANGLE_FRAC_BITS))) >>> (29 - ANGLE_FRAC_BITS);

    // Field widths
    localparam int OP_W      = 2;
    localparam int ETA_W     = 16;
    localparam int PHI_W     = 15;
    localparam int CHG_W     = 2;
    localparam int WIN_W     = 12;
    localparam int TIDX_W    = 8;
    localparam int DOUT_W    = 20;

    // Datapath widths
    localparam int ETA_D_W   = ETA_W + 1;
    localparam int PHI_D_W   = 20;
    localparam int QD_W      = PHI_D_W + 1;
    localparam int SQ_W      = 32;
    localparam int DIST_W    = SQ_W + 1;

    localparam logic signed [PHI_D_W-1:0] PI_D     = PHI_D_W'(PI_FIX);
    localparam logic signed [PHI_D_W-1:0] TWO_PI_D = PHI_D_W'(2 * PI_FIX);
    localparam logic [DOUT_W-1:0]         DIST_MAX = {DOUT_W{1'b1}};

    // Operation codes
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ETA_WIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_FWD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PHI_BWD = 2'd2;

    // Charge codes after normalization
    localparam logic [CHG_W-1:0] CHG_POS = 2'b01;
    localparam logic [CHG_W-1:0] CHG_NEG = 2'b11;

    // One stored track
    typedef struct packed {
        logic signed [ETA_W-1:0] eta;
        logic signed [PHI_W-1:0] phi;
        logic        [CHG_W-1:0] chg;
    } t_track;

    // Window registers
    typedef struct packed {
        logic [WIN_W-1:0] eta_win;
        logic [WIN_W-1:0] phi_fwd;
        logic [WIN_W-1:0] phi_bwd;
    } t_cfg;

    // Scan tag that travels with each read
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // Candidate leaving the match unit
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              pass;
        logic [IDX_W-1:0]  idx;
        logic [DIST_W-1:0] dsq;
    } t_cand;

endpackage
`default_nettype wire

FILE: rtl/core/tcwm_item_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcwm_item_if
// Input channel: clear, load-track and query items.
// ----------------------------------------------------------------------------
interface tcwm_item_if import tcwm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [OP_W-1:0]         op;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic signed [CHG_W-1:0] charge;

    modport source (output valid, op, eta, phi, charge, input ready);
    modport sink   (input valid, op, eta, phi, charge, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcwm_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcwm_result_if
// Result channel: one item per query.
// ----------------------------------------------------------------------------
interface tcwm_result_if import tcwm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [TIDX_W-1:0] track_index;
    logic [DOUT_W-1:0] dist_sq;

    modport source (output valid, found, track_index, dist_sq, input ready);
    modport sink   (input valid, found, track_index, dist_sq, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/tcwm_track_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcwm_track_store
// Track table: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcwm_track_store import tcwm_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [IDX_W-1:0] i_waddr,
    input  wire t_track           i_wdata,
    input  wire logic [IDX_W-1:0] i_raddr,
    output t_track                o_rdata
);

    t_track r_mem [MAX_TRACKS];
    t_track r_rdata;

    // Write on load
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read during scan
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: rtl/core/tcwm_match_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcwm_match_unit
// Shared per-track datapath: deltas with phi wrap, window test, squares and
// squared delta-R. One track enters per cycle; results leave registered.
// ----------------------------------------------------------------------------
module tcwm_match_unit import tcwm_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_tag                    i_tag,     // aligned with read address
    input  wire t_track                  i_track,   // read data, in the cycle after the tag
    input  wire logic signed [ETA_W-1:0] i_cl_eta,
    input  wire logic signed [PHI_W-1:0] i_cl_phi,
    input  wire t_cfg                    i_cfg,
    output t_cand                        o_cand
);

    t_tag r_tag_m, r_tag_a, r_tag_b;
    t_cand r_cand;

    logic signed [ETA_D_W-1:0] r_deta, n_deta;
    logic signed [PHI_D_W-1:0] r_dphi, n_dphi;
    logic        [CHG_W-1:0]   r_chg;
    logic                      r_pass_b, n_pass_b;
    logic        [SQ_W-1:0]    r_sq_eta, r_sq_phi;

    logic signed [PHI_D_W-1:0]   w_dphi_raw;
    logic        [ETA_D_W-1:0]   w_adeta;
    logic signed [QD_W-1:0]      w_qd;
    logic signed [QD_W-1:0]      w_fwd, w_bwd_neg;
    logic signed [2*ETA_D_W-1:0] w_prod_eta;
    logic signed [2*PHI_D_W-1:0] w_prod_phi;

    // Tag pipeline, valid cleared on reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_m <= '0;
            r_tag_a <= '0;
            r_tag_b <= '0;
            r_cand  <= '0;
        end else begin
            r_tag_m <= i_tag;
            r_tag_a <= r_tag_m;
            r_tag_b <= r_tag_a;
            r_cand.valid <= r_tag_b.valid;
            r_cand.last  <= r_tag_b.last;
            r_cand.idx   <= r_tag_b.idx;
            r_cand.pass  <= r_pass_b;
            r_cand.dsq   <= DIST_W'(r_sq_eta) + DIST_W'(r_sq_phi);
        end
    end

    // Stage A: differences, single phi wrap correction
    always_comb begin
        n_deta     = ETA_D_W'($signed(i_track.eta)) - ETA_D_W'(i_cl_eta);
        w_dphi_raw = PHI_D_W'($signed(i_track.phi)) - PHI_D_W'(i_cl_phi);
        if (w_dphi_raw > PI_D) begin
            n_dphi = w_dphi_raw - TWO_PI_D;
        end else if (w_dphi_raw < -PI_D) begin
            n_dphi = w_dphi_raw + TWO_PI_D;
        end else begin
            n_dphi = w_dphi_raw;
        end
    end

    always_ff @(posedge i_clk) begin
        r_deta <= n_deta;
        r_dphi <= n_dphi;
        r_chg  <= i_track.chg;
    end

    // Stage B: window test and squares
    always_comb begin
        w_adeta = r_deta[ETA_D_W-1] ? ETA_D_W'(-r_deta) : ETA_D_W'(r_deta);
        case (r_chg)
            CHG_POS: w_qd = QD_W'(r_dphi);
            CHG_NEG: w_qd = -QD_W'(r_dphi);
            default: w_qd = '0;
        endcase
        w_fwd     = $signed(QD_W'(i_cfg.phi_fwd));
        w_bwd_neg = -$signed(QD_W'(i_cfg.phi_bwd));
        n_pass_b  = (w_adeta < ETA_D_W'(i_cfg.eta_win)) && (w_qd < w_fwd)
                    && (w_qd > w_bwd_neg);
        w_prod_eta = r_deta * r_deta;
        w_prod_phi = r_dphi * r_dphi;
    end

    always_ff @(posedge i_clk) begin
        r_pass_b <= n_pass_b;
        r_sq_eta <= w_prod_eta[SQ_W-1:0];
        r_sq_phi <= w_prod_phi[SQ_W-1:0];
    end

    assign o_cand = r_cand;

endmodule
`default_nettype wire

FILE: rtl/core/track_cluster_window_match_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// track_cluster_window_match_top
// Loads track extrapolations into a table and answers cluster queries with
// the nearest track inside the eta / charge-signed phi window.
//
//   channel   dir  handshake     payload
//   i_item    in   valid/ready   op, eta, phi, charge
//   o_result  out  valid/ready   found, track_index, dist_sq
//   i_cfg_*   in   write enable  register index, 12-bit data
//
// Clear and load items are handled in the idle state. A query scans the N
// stored tracks (an empty table skips the scan): the table read port and
// the match unit handle one track per cycle, and the answer goes to the
// output register. No new item is taken until that register is loaded.
// Reset empties the table (count to zero) and restores the window values.
// A result waiting on o_result does not block new items; a finished query
// holds only while the previous result is still not taken.
// ----------------------------------------------------------------------------
module track_cluster_window_match_top import tcwm_pkg::*; (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    tcwm_item_if.sink                 i_item,
    tcwm_result_if.source             o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [WIN_W-1:0]     i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CNT_W-1:0]        r_count;
    logic [CNT_W-1:0]        r_scan_idx;
    t_cfg                    r_cfg;
    logic signed [ETA_W-1:0] r_cl_eta;
    logic signed [PHI_W-1:0] r_cl_phi;
    logic                    r_found;
    logic [IDX_W-1:0]        r_best_idx;
    logic [DIST_W-1:0]       r_best_d;
    logic                    r_out_valid;
    logic                    r_out_found;
    logic [TIDX_W-1:0]       r_out_idx;
    logic [DOUT_W-1:0]       r_out_dist;

    logic   w_accept;
    logic   w_load_we;
    logic   w_slot_free;
    logic   w_better;
    t_tag   w_tag;
    t_track w_wdata;
    t_track w_rdata;
    t_cand  w_cand;

    assign w_accept    = i_item.valid && i_item.ready;
    assign w_load_we   = w_accept && (i_item.op == OP_LOAD) && (r_count < CNT_W'(MAX_TRACKS));
    assign w_slot_free = !r_out_valid || o_result.ready;
    assign i_item.ready = (r_state == S_IDLE);

    // Charge normalized on load: any negative code stored as minus one
    assign w_wdata.eta = i_item.eta;
    assign w_wdata.phi = i_item.phi;
    assign w_wdata.chg = i_item.charge[CHG_W-1] ? CHG_NEG : i_item.charge;

    // Read tag for the current scan position
    assign w_tag.valid = (r_state == S_ISSUE);
    assign w_tag.last  = (CNT_W'(r_scan_idx + 1'b1) == r_count);
    assign w_tag.idx   = r_scan_idx[IDX_W-1:0];

    tcwm_track_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_load_we),
        .i_waddr (r_count[IDX_W-1:0]),
        .i_wdata (w_wdata),
        .i_raddr (r_scan_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    tcwm_match_unit u_match (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (w_tag),
        .i_track  (w_rdata),
        .i_cl_eta (r_cl_eta),
        .i_cl_phi (r_cl_phi),
        .i_cfg    (r_cfg),
        .o_cand   (w_cand)
    );

    // Sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.op == OP_QUERY)) begin
                    n_state = (r_count == '0) ? S_DONE : S_ISSUE;
                end
            end
            S_ISSUE: begin
                if (w_tag.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_cand.valid && w_cand.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Candidate beats the best so far; earlier track wins ties
    assign w_better = w_cand.valid && w_cand.pass && (!r_found || (w_cand.dsq < r_best_d));

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_count       <= '0;
            r_scan_idx    <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
            r_cfg.eta_win <= WIN_W'(205);
            r_cfg.phi_fwd <= WIN_W'(205);
            r_cfg.phi_bwd <= WIN_W'(410);
        end else begin
            r_state <= n_state;

            // Table count
            if (w_accept && (i_item.op == OP_CLEAR)) begin
                r_count <= '0;
            end else if (w_load_we) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end

            // Scan position
            if (w_accept) begin
                r_scan_idx <= '0;
            end else if (r_state == S_ISSUE) begin
                r_scan_idx <= CNT_W'(r_scan_idx + 1'b1);
            end

            // Found flag
            if (w_accept) begin
                r_found <= 1'b0;
            end else if (w_better) begin
                r_found <= 1'b1;
            end

            // Output register
            if (r_state == S_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end

            // Window registers
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_ETA_WIN: r_cfg.eta_win <= i_cfg_data;
                    REG_PHI_FWD: r_cfg.phi_fwd <= i_cfg_data;
                    REG_PHI_BWD: r_cfg.phi_bwd <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cl_eta <= i_item.eta;
            r_cl_phi <= i_item.phi;
        end
        if (w_better) begin
            r_best_idx <= w_cand.idx;
            r_best_d   <= w_cand.dsq;
        end
        if (r_state == S_DONE && w_slot_free) begin
            r_out_found <= r_found;
            r_out_idx   <= r_found ? TIDX_W'(r_best_idx) : '0;
            if (!r_found) begin
                r_out_dist <= '0;
            end else if (r_best_d > DIST_W'(DIST_MAX)) begin
                r_out_dist <= DIST_MAX;
            end else begin
                r_out_dist <= r_best_d[DOUT_W-1:0];
            end
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.found       = r_out_found;
    assign o_result.track_index = r_out_idx;
    assign o_result.dist_sq     = r_out_dist;

    // Scan reads stay inside the loaded part of the table
    ap_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ISSUE) |-> (r_scan_idx < r_count))
        else $error("scan index beyond track count");

    // The last candidate of a scan closes the query
    ap_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRAIN && w_cand.valid && w_cand.last) |=> (r_state == S_DONE))
        else $error("scan end not followed by result");

    // A query without a match reports zero index and distance
    ap_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && !o_result.found) |->
        (o_result.track_index == '0 && o_result.dist_sq == '0))
        else $error("no-match result carries data");

    // Table count never exceeds capacity
    ap_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_TRACKS))
        else $error("track count over capacity");

endmodule
`default_nettype wire

FILE: verif/tcwm_match_checker.sv
// ----------------------------------------------------------------------------
// tcwm_match_checker
// Watches the item, result and register ports of the window matcher. It keeps
// its own copy of the track table and windows, works out the nearest-track
// answer for every accepted query, and compares each result in order.
// ----------------------------------------------------------------------------
module tcwm_match_checker import tcwm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    tcwm_item_if                 i_item,
    tcwm_result_if               i_result,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WIN_W-1:0]     i_cfg_data,
    output int                   o_fails,
    output int                   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // round(pi * 2^12)
    localparam longint HALF_TURN = 64'sd12868;
    localparam longint DIST_CAP  = (64'sd1 <<< DOUT_W) - 1;

    typedef struct packed {
        logic              found;
        logic [TIDX_W-1:0] track_index;
        logic [DOUT_W-1:0] dist_sq;
    } t_match;

    // Shadow track table and window registers
    logic signed [ETA_W-1:0] trk_eta  [MAX_TRACKS];
    logic signed [PHI_W-1:0] trk_phi  [MAX_TRACKS];
    int                      trk_sign [MAX_TRACKS];
    int                      n_tracks;
    logic [WIN_W-1:0]        win_eta;
    logic [WIN_W-1:0]        win_fwd;
    logic [WIN_W-1:0]        win_bwd;

    t_match expected_matches[$];
    int     mismatch_count;

    assign o_fails = mismatch_count;

    task automatic report_mismatch(input string what);
        $display("%0t ns: match check: %s", $time, what);
        mismatch_count++;
    endtask

    // Nearest passing track by squared delta-R, earliest track wins ties
    function automatic t_match nearest_track(input logic signed [ETA_W-1:0] c_eta,
                                             input logic signed [PHI_W-1:0] c_phi);
        t_match m;
        longint deta;
        longint dphi;
        longint adeta;
        longint qd;
        longint d;
        longint best;
        bit     hit;
        m    = '0;
        best = 0;
        hit  = 1'b0;
        for (int i = 0; i < n_tracks; i++) begin
            deta = longint'(trk_eta[i]) - longint'(c_eta);
            dphi = longint'(trk_phi[i]) - longint'(c_phi);
            // single wrap correction: values beyond pi or below -pi move by 2 pi
            if (dphi > HALF_TURN) begin
                dphi -= 2 * HALF_TURN;
            end else if (dphi < -HALF_TURN) begin
                dphi += 2 * HALF_TURN;
            end
            adeta = (deta < 0) ? -deta : deta;
            qd    = dphi * trk_sign[i];
            if (adeta < longint'(win_eta) && qd < longint'(win_fwd)
                    && qd > -longint'(win_bwd)) begin
                d = deta * deta + dphi * dphi;
                if (!hit || d < best) begin
                    hit           = 1'b1;
                    best          = d;
                    m.track_index = TIDX_W'(i);
                end
            end
        end
        m.found   = hit;
        m.dist_sq = (best > DIST_CAP) ? DOUT_W'(DIST_CAP) : DOUT_W'(best);
        return m;
    endfunction

    always @(posedge i_clk) begin
        t_match got;
        t_match want;
        if (!i_rst_n) begin
            n_tracks       = 0;
            win_eta        = 12'd205;
            win_fwd        = 12'd205;
            win_bwd        = 12'd410;
            mismatch_count = 0;
            expected_matches.delete();
        end else begin
            // results first: a result never belongs to a query taken this cycle
            if (i_result.valid && i_result.ready) begin
                got.found       = i_result.found;
                got.track_index = i_result.track_index;
                got.dist_sq     = i_result.dist_sq;
                if (expected_matches.size() == 0) begin
                    report_mismatch($sformatf("result with no query waiting: %0b %0d %0d",
                                    got.found, got.track_index, got.dist_sq));
                end else begin
                    want = expected_matches.pop_front();
                    if (got.found !== want.found)
                        report_mismatch($sformatf("found %0b, want %0b",
                                        got.found, want.found));
                    if (got.track_index !== want.track_index)
                        report_mismatch($sformatf("track_index %0d, want %0d",
                                        got.track_index, want.track_index));
                    if (got.dist_sq !== want.dist_sq)
                        report_mismatch($sformatf("dist_sq %0d, want %0d",
                                        got.dist_sq, want.dist_sq));
                end
            end

            // item side: update the table or predict the answer
            if (i_item.valid && i_item.ready) begin
                case (i_item.op)
                    OP_CLEAR: begin
                        n_tracks = 0;
                    end
                    OP_LOAD: begin
                        // loads past capacity are dropped
                        if (n_tracks < MAX_TRACKS) begin
                            trk_eta[n_tracks]  = i_item.eta;
                            trk_phi[n_tracks]  = i_item.phi;
                            trk_sign[n_tracks] = i_item.charge[CHG_W-1] ? -1
                                                 : int'(i_item.charge);
                            n_tracks++;
                        end
                    end
                    OP_QUERY: begin
                        expected_matches.insert(expected_matches.size(),
                                                nearest_track(i_item.eta, i_item.phi));
                    end
                    default: ;
                endcase
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ETA_WIN: win_eta = i_cfg_data;
                    REG_PHI_FWD: win_fwd = i_cfg_data;
                    REG_PHI_BWD: win_bwd = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending <= expected_matches.size();
    end

endmodule

FILE: verif/tb_track_cluster_window_match_top.sv
// ----------------------------------------------------------------------------
// tb_track_cluster_window_match_top
// Drives clear, load and query items into the window matcher with random
// gaps and result back-pressure, sweeps the window registers through their
// extremes and random values, and lets the checker score every result.
// ----------------------------------------------------------------------------
module tb_track_cluster_window_match_top import tcwm_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 650;
    localparam int CALM_ITEMS   = 120;
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = MAX_TRACKS + 40;
    localparam int HALF_TURN    = 12868;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [WIN_W-1:0]     cfg_data;

    tcwm_item_if   item_ch();
    tcwm_result_if result_ch();

    int fails;
    int pending;
    int items_sent;
    int quiet_cycles = 0;
    int stall_left = 0;
    bit sender_idles;
    bit sink_stalls;
    int cur_eta_win;
    int cur_fwd_win;
    int cur_bwd_win;

    // tracks the block should hold, used to aim queries
    logic signed [ETA_W-1:0] loaded_eta[$];
    logic signed [PHI_W-1:0] loaded_phi[$];

    track_cluster_window_match_top u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .o_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    tcwm_match_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (item_ch),
        .i_result   (result_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_fails    (fails),
        .o_pending  (pending)
    );

    always #10 i_clk = ~i_clk;

    // Result back-pressure in random bursts
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= stall_left - 1;
        end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 10);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Watchdog on cycles with no handshake, register write or reset
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || cfg_we || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_track_cluster_window_match_top failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic signed [ETA_W-1:0] pick_eta();
        if ($urandom_range(0, 4) == 0)
            return ETA_W'($urandom);
        return ETA_W'(int'($urandom_range(0, 40959)) - 20480);
    endfunction

    // mix of any code, the nominal range and both edges of the wrap
    function automatic logic signed [PHI_W-1:0] pick_phi();
        case ($urandom_range(0, 3))
            0:       return PHI_W'($urandom);
            1:       return PHI_W'(int'($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
            2:       return PHI_W'(HALF_TURN - int'($urandom_range(0, 400)));
            default: return PHI_W'(int'($urandom_range(0, 400)) - HALF_TURN);
        endcase
    endfunction

    // One item, with an optional gap in front of it
    task automatic send_item(input logic [OP_W-1:0]         op,
                             input logic signed [ETA_W-1:0] eta,
                             input logic signed [PHI_W-1:0] phi,
                             input logic signed [CHG_W-1:0] chg);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        item_ch.valid  <= 1'b1;
        item_ch.op     <= op;
        item_ch.eta    <= eta;
        item_ch.phi    <= phi;
        item_ch.charge <= chg;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        if (op != OP_SPARE)
            items_sent++;
        if (op == OP_CLEAR) begin
            loaded_eta.delete();
            loaded_phi.delete();
        end else if (op == OP_LOAD && loaded_eta.size() < MAX_TRACKS) begin
            loaded_eta.insert(loaded_eta.size(), eta);
            loaded_phi.insert(loaded_phi.size(), phi);
        end
    endtask

    // Block idle: no result owed and any trailing load or clear finished
    task automatic settle();
        item_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_windows(input logic [WIN_W-1:0] w_eta,
                               input logic [WIN_W-1:0] w_fwd,
                               input logic [WIN_W-1:0] w_bwd);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_ETA_WIN;
        cfg_data <= w_eta;
        @(posedge i_clk);
        cfg_idx  <= REG_PHI_FWD;
        cfg_data <= w_fwd;
        @(posedge i_clk);
        cfg_idx  <= REG_PHI_BWD;
        cfg_data <= w_bwd;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        cur_eta_win = w_eta;
        cur_fwd_win = w_fwd;
        cur_bwd_win = w_bwd;
    endtask

    // Query aimed at a loaded track, offset by up to 20 past the windows
    task automatic send_aimed_query();
        int j;
        int eta_span;
        int phi_span;
        j        = $urandom_range(0, loaded_eta.size() - 1);
        eta_span = cur_eta_win + 20;
        phi_span = ((cur_fwd_win > cur_bwd_win) ? cur_fwd_win : cur_bwd_win) + 20;
        send_item(OP_QUERY,
                  ETA_W'(int'(loaded_eta[j]) + int'($urandom_range(0, 2 * eta_span))
                         - eta_span),
                  PHI_W'(int'(loaded_phi[j]) + int'($urandom_range(0, 2 * phi_span))
                         - phi_span),
                  CHG_W'($urandom_range(0, 3)));
    endtask

    initial begin
        int phase;
        int loads_left;
        int queries_left;
        int roll;

        item_ch.valid   <= 1'b0;
        item_ch.op      <= OP_CLEAR;
        item_ch.eta     <= '0;
        item_ch.phi     <= '0;
        item_ch.charge  <= '0;
        cfg_we          <= 1'b0;
        cfg_idx         <= REG_ETA_WIN;
        cfg_data        <= '0;
        items_sent      = 0;
        cur_eta_win     = 205;
        cur_fwd_win     = 205;
        cur_bwd_win     = 410;
        sender_idles    = 1'b1;
        sink_stalls     = 1'b1;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset windows
        send_item(OP_QUERY, 16'sd0, 15'sd0, 2'sd0);            // empty table
        send_item(OP_LOAD, 16'sd0, 15'sd0, 2'sd1);
        send_item(OP_LOAD, 16'sd0, 15'sd0, -2'sd1);            // exact tie with track 0
        send_item(OP_LOAD, 16'sd20479, 15'sd12868, -2'sd2);    // code -2 acts as -1
        send_item(OP_LOAD, -16'sd20480, -15'sd12868, 2'sd0);   // neutral track
        send_item(OP_LOAD, -16'sd32768, -15'sd16384, 2'sd1);
        send_item(OP_LOAD, 16'sd32767, 15'sd16383, -2'sd1);
        send_item(OP_LOAD, 16'sd150, -15'sd300, 2'sd1);        // behind, inside backward
        send_item(OP_QUERY, 16'sd0, 15'sd0, 2'sd1);            // tie: earliest wins
        send_item(OP_QUERY, 16'sd20479, -15'sd12868, 2'sd0);   // wraps down by 2 pi
        send_item(OP_QUERY, -16'sd20480, 15'sd12868, 2'sd0);   // wraps up by 2 pi
        send_item(OP_QUERY, 16'sd32767, 15'sd16383, -2'sd2);
        send_item(OP_QUERY, -16'sd32768, -15'sd16384, 2'sd1);
        send_item(OP_QUERY, 16'sd150, -15'sd100, 2'sd0);
        send_item(OP_QUERY, 16'sd1000, 15'sd1000, 2'sd0);      // nothing in window
        send_item(OP_SPARE, 16'sd77, 15'sd77, 2'sd1);          // ignored
        send_item(OP_CLEAR, 16'sd0, 15'sd0, 2'sd0);
        send_item(OP_QUERY, 16'sd0, 15'sd0, 2'sd0);            // cleared table
        send_item(OP_LOAD, 16'sd10, -15'sd10, 2'sd1);
        send_item(OP_QUERY, 16'sd0, 15'sd0, 2'sd0);

        // Random phases, each on its own window setting
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            settle();
            case (phase)
                0:       set_windows(12'd4095, 12'd4095, 12'd4095);
                1:       set_windows(12'd0, 12'd0, 12'd0);
                2:       set_windows(12'd1, 12'd4095, 12'd1);
                3:       set_windows(12'd205, 12'd205, 12'd410);
                default: begin
                    if ($urandom_range(0, 3) == 0)
                        set_windows(WIN_W'($urandom), WIN_W'($urandom), WIN_W'($urandom));
                    else
                        set_windows(WIN_W'($urandom_range(40, 900)),
                                    WIN_W'($urandom_range(40, 900)),
                                    WIN_W'($urandom_range(40, 900)));
                end
            endcase

            // no idling at all near the end, and some quiet phases before
            if (items_sent >= ITEM_TARGET - CALM_ITEMS) begin
                sender_idles = 1'b0;
                sink_stalls  = 1'b0;
            end else begin
                sender_idles = (phase % 4 != 1);
                sink_stalls  = (phase % 4 != 2);
            end

            send_item(OP_CLEAR, pick_eta(), pick_phi(), CHG_W'($urandom_range(0, 3)));
            // one phase overfills the table
            loads_left   = (phase == 4) ? MAX_TRACKS + 3 : $urandom_range(1, 24);
            queries_left = $urandom_range(8, 24);
            while (loads_left > 0 || queries_left > 0) begin
                roll = $urandom_range(0, 99);
                if (loads_left > 0 && (roll < 50 || queries_left == 0)) begin
                    send_item(OP_LOAD, pick_eta(), pick_phi(), CHG_W'($urandom_range(0, 3)));
                    loads_left--;
                end else if (roll < 94 || loads_left == 0) begin
                    if (loaded_eta.size() > 0 && $urandom_range(0, 9) < 7)
                        send_aimed_query();
                    else
                        send_item(OP_QUERY, pick_eta(), pick_phi(),
                                  CHG_W'($urandom_range(0, 3)));
                    queries_left--;
                end else if (roll < 98) begin
                    send_item(OP_SPARE, pick_eta(), pick_phi(), CHG_W'($urandom_range(0, 3)));
                end else begin
                    send_item(OP_CLEAR, pick_eta(), pick_phi(), CHG_W'($urandom_range(0, 3)));
                end
            end
            phase++;
        end

        // Drain and verdict
        settle();
        if (fails == 0 && pending == 0) begin
            $display("tb_track_cluster_window_match_top passed");
        end else begin
            $display("tb_track_cluster_window_match_top failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/tcwm_pkg.sv
rtl/core/tcwm_item_if.sv
rtl/core/tcwm_result_if.sv
rtl/core/tcwm_track_store.sv
rtl/core/tcwm_match_unit.sv
rtl/core/track_cluster_window_match_top.sv
verif/tcwm_match_checker.sv
verif/tb_track_cluster_window_match_top.sv
